// ===== rtl/core/tmpg_pkg.sv =====
`default_nettype none
// ============================================================================
// tmpg_pkg: text mode pixel generator shared definitions
// Command codes, store geometry, pixel result type and color scaling.
// ============================================================================
package tmpg_pkg;

    localparam int TEXT_COLUMNS_DEF = 32;
    localparam int TEXT_ROWS_DEF    = 12;
    localparam int GLYPH_WORDS      = 256;
    localparam int GLYPH_ROWS       = GLYPH_WORDS / 2;
    localparam int GLYPH_AW         = $clog2(GLYPH_ROWS);
    localparam int PALETTE_ENTRIES  = 16;
    localparam int PAL_AW           = $clog2(PALETTE_ENTRIES);

    localparam logic [2:0] CMD_WRITE_CELL    = 3'd0;
    localparam logic [2:0] CMD_WRITE_GLYPH   = 3'd1;
    localparam logic [2:0] CMD_WRITE_PALETTE = 3'd2;
    localparam logic [2:0] CMD_RENDER        = 3'd3;
    localparam logic [2:0] CMD_BORDER        = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_fg;
    } t_pixel;

    // nibble * 15 = nibble * 16 - nibble
    function automatic logic [7:0] f_scale15(input logic [3:0] nib);
        return {nib, 4'b0000} - {4'b0000, nib};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tmpg_out_buf.sv =====
`default_nettype none
// ============================================================================
// tmpg_out_buf: pixel result output register with skid stage
// Holds up to two results so the pipeline stalls only once the skid stage is full.
// ============================================================================
module tmpg_out_buf (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  tmpg_pkg::t_pixel i_data,
    input  wire              i_stall,
    output logic             o_valid,
    output tmpg_pkg::t_pixel o_data,
    output logic             o_full
);
    import tmpg_pkg::*;

    logic   r_out_valid, n_out_valid;
    logic   r_skid_valid, n_skid_valid;
    t_pixel r_out, n_out;
    t_pixel r_skid, n_skid;
    logic   pop;

    assign pop = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_out        = i_data;
                n_out_valid  = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid)
        else $error("skid result lost on drain");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && r_out_valid && i_stall && !i_push |=> r_skid_valid)
        else $error("held skid result dropped");

endmodule
`default_nettype wire

// ===== rtl/core/text_mode_pixel_generator_unit.sv =====
`default_nettype none
// ============================================================================
// text_mode_pixel_generator_unit: text mode character cell pixel generator
// Cell, glyph and palette stores with a render pipeline giving RGB pixels.
// ============================================================================
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall | command, address, data, x, y
//  out     | output    | o_out_valid/i_out_stall | red, green, blue, is_foreground
//  cfg     | input     | i_cfg_we                | border color index
//
//  One transaction per cycle while o_in_stall is low; a result passes the cell
//  read register, the glyph read register, then palette and scaling into the
//  output register. After reset the cell and glyph memories are swept, one
//  entry per cycle; o_in_stall is high meanwhile. o_in_stall also rises while
//  the skid stage holds a result.
// ============================================================================
module text_mode_pixel_generator_unit #(
    parameter int TEXT_COLUMNS = tmpg_pkg::TEXT_COLUMNS_DEF,
    parameter int TEXT_ROWS    = tmpg_pkg::TEXT_ROWS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_command,
    input  wire  [8:0]  i_address,
    input  wire  [15:0] i_write_data,
    input  wire  [6:0]  i_pixel_x,
    input  wire  [6:0]  i_pixel_y,
    input  wire         i_cfg_we,
    input  wire  [3:0]  i_cfg_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_is_foreground
);
    import tmpg_pkg::*;

    localparam int CELL_WORDS = TEXT_COLUMNS * TEXT_ROWS;
    localparam int CELL_AW    = (CELL_WORDS > 1) ? $clog2(CELL_WORDS) : 1;
    localparam int CLR_DEPTH  = (CELL_WORDS > GLYPH_ROWS) ? CELL_WORDS : GLYPH_ROWS;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    // control
    logic             r_clearing;
    logic [CLR_W-1:0] r_clr;
    logic [3:0]       r_border;
    logic             buf_full;
    logic             adv;
    logic             in_acc;
    logic             is_render;
    logic             is_border;

    // stage 0 decode
    logic [4:0]         col;
    logic [3:0]         row;
    logic               oob;

    // memories
    logic [15:0]         r_cell_mem [CELL_WORDS];
    logic [15:0]         r_ghi_mem  [GLYPH_ROWS];
    logic [15:0]         r_glo_mem  [GLYPH_ROWS];
    logic [11:0]         r_pal      [PALETTE_ENTRIES];
    logic                cell_we, cell_re;
    logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
    logic [15:0]         cell_wdata;
    logic                ghi_we, glo_we, glyph_re;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic [15:0]         glyph_wdata;
    logic [15:0]         r_cell_q;
    logic [15:0]         r_ghi_q, r_glo_q;

    // pipeline
    logic        r_p1_valid, r_p1_border;
    logic [1:0]  r_p1_sub_x;
    logic [2:0]  r_p1_sub_y;
    logic        r_p2_valid, r_p2_border;
    logic [1:0]  r_p2_sub_x;
    logic [2:0]  r_p2_sub_y;
    logic [3:0]  r_p2_fg, r_p2_bg;
    logic              r_p1_pal_we, r_p2_pal_we;
    logic [PAL_AW-1:0] r_p1_pal_addr, r_p2_pal_addr;
    logic [11:0]       r_p1_pal_data, r_p2_pal_data;
    logic [31:0] glyph;
    logic        font_bit;
    logic [3:0]  pal_idx;
    logic [11:0] pal_word;
    t_pixel      n_pix;
    t_pixel      out_pix;

    assign adv        = !buf_full;
    assign o_in_stall = r_clearing || buf_full;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_render  = (i_command == CMD_RENDER);
    assign is_border  = (i_command == CMD_BORDER);

    assign col = i_pixel_x[6:2];
    assign row = i_pixel_y[6:3];
    assign oob = (32'(col) >= TEXT_COLUMNS) || (32'(row) >= TEXT_ROWS);

    // clearing pass and border register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_border   <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_border <= i_cfg_data;
            end
        end
    end

    // cell memory
    always_comb begin
        if (r_clearing) begin
            cell_we    = (32'(r_clr) < CELL_WORDS);
            cell_waddr = r_clr[CELL_AW-1:0];
            cell_wdata = '0;
        end else begin
            cell_we    = in_acc && (i_command == CMD_WRITE_CELL)
                         && (32'(i_address) < CELL_WORDS);
            cell_waddr = CELL_AW'(i_address);
            cell_wdata = i_write_data;
        end
    end

    assign cell_re    = in_acc && is_render && !oob;
    assign cell_raddr = CELL_AW'(32'(row) * TEXT_COLUMNS + 32'(col));

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re) begin
            r_cell_q <= r_cell_mem[cell_raddr];
        end
    end

    // glyph memory: even words in the high bank, odd words in the low bank
    always_comb begin
        if (r_clearing) begin
            ghi_we      = (32'(r_clr) < GLYPH_ROWS);
            glo_we      = ghi_we;
            glyph_waddr = r_clr[GLYPH_AW-1:0];
            glyph_wdata = '0;
        end else begin
            ghi_we      = in_acc && (i_command == CMD_WRITE_GLYPH)
                          && !i_address[8] && !i_address[0];
            glo_we      = in_acc && (i_command == CMD_WRITE_GLYPH)
                          && !i_address[8] && i_address[0];
            glyph_waddr = i_address[GLYPH_AW:1];
            glyph_wdata = i_write_data;
        end
    end

    assign glyph_re = adv && r_p1_valid && !r_p1_border;

    always_ff @(posedge i_clk) begin
        if (ghi_we) begin
            r_ghi_mem[glyph_waddr] <= glyph_wdata;
        end
        if (glo_we) begin
            r_glo_mem[glyph_waddr] <= glyph_wdata;
        end
        if (glyph_re) begin
            r_ghi_q <= r_ghi_mem[r_cell_q[GLYPH_AW-1:0]];
            r_glo_q <= r_glo_mem[r_cell_q[GLYPH_AW-1:0]];
        end
    end

    // palette: writes land from stage 2, in order with the lookups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_pal[i] <= '0;
            end
        end else if (adv && r_p2_pal_we) begin
            r_pal[r_p2_pal_addr] <= r_p2_pal_data;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p1_pal_we <= 1'b0;
            r_p2_pal_we <= 1'b0;
        end else if (adv) begin
            r_p1_valid  <= in_acc && (is_render || is_border);
            r_p2_valid  <= r_p1_valid;
            r_p1_pal_we <= in_acc && (i_command == CMD_WRITE_PALETTE)
                           && (i_address[8:PAL_AW] == '0);
            r_p2_pal_we <= r_p1_pal_we;
        end
        if (adv) begin
            r_p1_border   <= is_border || oob;
            r_p1_sub_x    <= i_pixel_x[1:0];
            r_p1_sub_y    <= i_pixel_y[2:0];
            r_p1_pal_addr <= i_address[PAL_AW-1:0];
            r_p1_pal_data <= i_write_data[11:0];
            r_p2_border   <= r_p1_border;
            r_p2_sub_x    <= r_p1_sub_x;
            r_p2_sub_y    <= r_p1_sub_y;
            r_p2_fg       <= r_cell_q[15:12];
            r_p2_bg       <= r_cell_q[11:8];
            r_p2_pal_addr <= r_p1_pal_addr;
            r_p2_pal_data <= r_p1_pal_data;
        end
    end

    // font bit, palette lookup, scaling
    assign glyph    = {r_ghi_q, r_glo_q};
    assign font_bit = !r_p2_border && glyph[{~r_p2_sub_x, r_p2_sub_y}];

    always_comb begin
        priority if (r_p2_border) begin
            pal_idx = r_border;
        end else if (font_bit) begin
            pal_idx = r_p2_fg;
        end else begin
            pal_idx = r_p2_bg;
        end
    end

    assign pal_word    = r_pal[pal_idx];
    assign n_pix.red   = f_scale15(pal_word[11:8]);
    assign n_pix.green = f_scale15(pal_word[7:4]);
    assign n_pix.blue  = f_scale15(pal_word[3:0]);
    assign n_pix.is_fg = font_bit;

    tmpg_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p2_valid && adv),
        .i_data  (n_pix),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_pix),
        .o_full  (buf_full)
    );

    assign o_red           = out_pix.red;
    assign o_green         = out_pix.green;
    assign o_blue          = out_pix.blue;
    assign o_is_foreground = out_pix.is_fg;

    a_clear_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_p1_valid && !r_p2_valid)
        else $error("transaction in flight during memory clear");

    a_result_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_RENDER || i_command == CMD_BORDER) |=> r_p1_valid)
        else $error("render or border transaction dropped");

    a_border_not_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_valid && r_p2_border |-> !n_pix.is_fg)
        else $error("border color flagged as foreground");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_full && r_p2_valid |=> r_p2_valid)
        else $error("pipeline result lost while output full");

endmodule
`default_nettype wire
